>>> src/assert_macros.svh
// assert_macros.svh: assertion macros used by the checker file msk_checker.sv
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, ignored while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, ignored while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// next-cycle implication that also holds across reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> src/msk_pkg.sv
// msk_pkg: types and constants of the min tracking stack
// no dependencies; used by every module of the block
`default_nettype none

package msk_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int DATA_W      = 32;
   localparam int COUNT_W     = 7;

   typedef enum logic [0:0] {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_OVERFLOW  = 2'd2
   } status_type;

   typedef struct packed {
      op_type                    func;
      logic signed [DATA_W-1:0]  push_value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  top_value;
      logic signed [DATA_W-1:0]  min_value;
      logic [COUNT_W-1:0]        entry_count;
      logic                      is_empty;
      status_type                status;
   } rsp_type;

   // shift control for a row of cells
   typedef struct packed {
      logic push;
      logic pop;
   } shift_ctl_type;

endpackage

`default_nettype wire

>>> src/min_tracking_stack.sv
// min_tracking_stack: bounded stack of signed values that also reports the minimum
// depends on msk_pkg, msk_chain
`default_nettype none

// Each accepted item is a push or a pop and completes in the cycle it is accepted;
// its result is held in a single output register and shows on rsp_payload in the
// next cycle. Two rows of DEPTH cells (values and running minima) shift by one
// place on each push or pop that changes them, so one item is taken every clock
// as long as the result side does not stall; req_stall is high only while a held
// result is stalled. Storage is in the cells, so there is no clearing pass after
// reset. An underflowing pop or overflowing push returns a status and leaves the
// stack untouched. entry_count carries the low bits of the count.
module min_tracking_stack #(
   parameter int DEPTH = msk_pkg::STACK_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire msk_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output msk_pkg::rsp_type      rsp_payload
);
   import msk_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] min_count_ff, min_count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             accept;
   logic             stack_full, stack_empty;
   logic             do_push, do_pop, min_push, min_pop;
   shift_ctl_type    val_ctl, min_ctl;
   logic [DATA_W-1:0] val_head, val_next, min_head, min_next;
   status_type       status;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign stack_full  = (count_ff == CNT_W'(DEPTH));
   assign stack_empty = (count_ff == '0);

   always_comb begin
      do_push  = accept && (req_payload.func == OP_PUSH) && !stack_full;
      do_pop   = accept && (req_payload.func == OP_POP) && !stack_empty;
      // at-most keeps repeated minima on the minimum stack
      min_push = do_push && ((min_count_ff == '0) ||
                 (req_payload.push_value <= $signed(min_head)));
      min_pop  = do_pop && (min_count_ff != '0) && (min_head == val_head);

      val_ctl.push = do_push;
      val_ctl.pop  = do_pop;
      min_ctl.push = min_push;
      min_ctl.pop  = min_pop;

      count_in = count_ff;
      if (do_push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end

      min_count_in = min_count_ff;
      if (min_push) begin
         min_count_in = min_count_ff + CNT_W'(1);
      end else if (min_pop) begin
         min_count_in = min_count_ff - CNT_W'(1);
      end

      status = ST_OK;
      if (accept && (req_payload.func == OP_PUSH) && stack_full) begin
         status = ST_OVERFLOW;
      end else if (accept && (req_payload.func == OP_POP) && stack_empty) begin
         status = ST_UNDERFLOW;
      end

      rsp_in.status      = status;
      rsp_in.entry_count = COUNT_W'(count_in);
      rsp_in.is_empty    = (count_in == '0);

      if (do_push) begin
         rsp_in.top_value = req_payload.push_value;
      end else if (do_pop) begin
         rsp_in.top_value = val_next;
      end else begin
         rsp_in.top_value = val_head;
      end

      if (min_push) begin
         rsp_in.min_value = req_payload.push_value;
      end else if (min_pop) begin
         rsp_in.min_value = min_next;
      end else begin
         rsp_in.min_value = min_head;
      end

      // an empty stack reads zero for both values
      if (count_in == '0) begin
         rsp_in.top_value = '0;
         rsp_in.min_value = '0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   msk_chain #(
      .DEPTH(DEPTH),
      .WIDTH(DATA_W)
   ) u_val_chain (
      .clock    (clock),
      .ctl      (val_ctl),
      .push_data(req_payload.push_value),
      .head_data(val_head),
      .next_data(val_next)
   );

   msk_chain #(
      .DEPTH(DEPTH),
      .WIDTH(DATA_W)
   ) u_min_chain (
      .clock    (clock),
      .ctl      (min_ctl),
      .push_data(req_payload.push_value),
      .head_data(min_head),
      .next_data(min_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         min_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         min_count_ff <= min_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

>>> src/msk_cell.sv
// msk_cell: one stack entry, shifts towards the tail on push and towards the head on pop
// depends on msk_pkg
`default_nettype none

module msk_cell #(
   parameter int WIDTH = msk_pkg::DATA_W
) (
   input  wire logic                   clock,
   input  wire msk_pkg::shift_ctl_type ctl,
   input  wire logic [WIDTH-1:0]       up_data,
   input  wire logic [WIDTH-1:0]       down_data,
   output logic      [WIDTH-1:0]       data
);
   import msk_pkg::*;

   logic [WIDTH-1:0] data_ff;
   logic [WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.push) begin
         data_in = up_data;
      end else if (ctl.pop) begin
         data_in = down_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

`default_nettype wire

>>> src/msk_chain.sv
// msk_chain: a row of msk_cell entries forming one stack, head at cell 0
// depends on msk_pkg and msk_cell
`default_nettype none

module msk_chain #(
   parameter int DEPTH = msk_pkg::STACK_DEPTH,
   parameter int WIDTH = msk_pkg::DATA_W
) (
   input  wire logic                   clock,
   input  wire msk_pkg::shift_ctl_type ctl,
   input  wire logic [WIDTH-1:0]       push_data,
   output logic      [WIDTH-1:0]       head_data,
   output logic      [WIDTH-1:0]       next_data
);
   import msk_pkg::*;

   logic [WIDTH-1:0] cell_data [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WIDTH-1:0] up_data;
      logic [WIDTH-1:0] down_data;

      if (i == 0) begin : g_head
         assign up_data = push_data;
      end else begin : g_body
         assign up_data = cell_data[i-1];
      end

      // the last cell keeps its own value on a pop, it is never read again
      if (i == DEPTH-1) begin : g_tail
         assign down_data = cell_data[i];
      end else begin : g_inner
         assign down_data = cell_data[i+1];
      end

      msk_cell #(
         .WIDTH(WIDTH)
      ) u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .up_data  (up_data),
         .down_data(down_data),
         .data     (cell_data[i])
      );
   end

   assign head_data = cell_data[0];
   assign next_data = cell_data[1];

endmodule

`default_nettype wire

>>> src/msk_checker.sv
// msk_checker: port-level checks on min_tracking_stack, bound to the top level
// depends on msk_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module msk_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_stall,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_stall,
   input  wire msk_pkg::rsp_type rsp_payload
);
   import msk_pkg::*;

   logic req_seen;
   logic held_rsp;
   logic empty_match;
   logic empty_zero;

   assign req_seen    = req_valid & ~req_stall;
   assign held_rsp    = rsp_valid & rsp_stall;
   assign empty_match = rsp_payload.is_empty == (rsp_payload.entry_count == '0);
   assign empty_zero  = (rsp_payload.top_value == '0) && (rsp_payload.min_value == '0);

   `ASSERT_NEXT_ALWAYS(a_reset_clears, clock, reset, !rsp_valid)
   `ASSERT_NEXT(a_item_gives_result, clock, reset, req_seen, rsp_valid)
   `ASSERT_NEXT(a_held_stable, clock, reset, held_rsp, rsp_valid && $stable(rsp_payload))
   `ASSERT_IMPLY(a_empty_flag, clock, reset, rsp_valid, empty_match)
   `ASSERT_IMPLY(a_empty_reads_zero, clock, reset, rsp_valid && rsp_payload.is_empty,
      empty_zero)

endmodule

bind min_tracking_stack msk_checker u_msk_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_payload(rsp_payload)
);

`default_nettype wire
